[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define LZD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define LZD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

[hw/rtl/lzd_pkg.sv]
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared widths, codes and defaults of the LZSS block decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lzd_pkg;

  localparam int WINDOW_DEPTH_DEF     = 32768;
  localparam int MAX_BLOCK_DEF        = 65536;
  localparam int BYTES_PER_RESULT_DEF = 8;

  localparam int LEN_W   = 17;
  localparam int DIST_W  = 16;
  localparam int OUT_W   = 64;
  localparam int BCNT_W  = 4;
  localparam int ERR_W   = 3;
  localparam int MLEN_W  = 9;
  localparam int SLOT_W  = 4;

  localparam int MIN_MATCH = 3;
  localparam int FLAG_BITS = 8;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic [ERR_W-1:0] E_OK       = 3'd0;
  localparam logic [ERR_W-1:0] E_TRUNC    = 3'd1;
  localparam logic [ERR_W-1:0] E_BAD_DIST = 3'd2;
  localparam logic [ERR_W-1:0] E_OVERRUN  = 3'd3;
  localparam logic [ERR_W-1:0] E_UNUSED   = 3'd4;
  localparam logic [ERR_W-1:0] E_TRAIL    = 3'd5;

  localparam logic [1:0] PH_FLAG    = 2'd0;
  localparam logic [1:0] PH_TOKEN   = 2'd1;
  localparam logic [1:0] PH_DIST_HI = 2'd2;
  localparam logic [1:0] PH_LEN     = 2'd3;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_ACTIVE  = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/lzd_stream_if.sv]
// ----------------------------------------------------------------------------
// lzd_stream_if
// Valid/ready channels for compressed input and decoded results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lzd_in_if;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [7:0]               byte_value;
  logic [lzd_pkg::LEN_W-1:0] block_length;
  logic                     last_byte;

  modport source (output valid, opcode, byte_value, block_length, last_byte, input ready);
  modport sink   (input valid, opcode, byte_value, block_length, last_byte, output ready);
endinterface

interface lzd_out_if;
  logic                      valid;
  logic                      ready;
  logic [lzd_pkg::OUT_W-1:0]  out_bytes;
  logic [lzd_pkg::BCNT_W-1:0] byte_count;
  logic                      last_of_run;
  logic                      block_done;
  logic [lzd_pkg::ERR_W-1:0]  error_code;

  modport source (output valid, out_bytes, byte_count, last_of_run, block_done, error_code,
                  input ready);
  modport sink   (input valid, out_bytes, byte_count, last_of_run, block_done, error_code,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/lzss_flag_group_block_decoder.sv]
// ----------------------------------------------------------------------------
// lzss_flag_group_block_decoder
// LZSS flag-group block decoder with a history RAM.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per transfer: a begin (opcode 0) with the decoded
//   block length, or one compressed byte (opcode 1) with last_byte on the
//   final byte of the block. res carries up to BYTES_PER_RESULT decoded
//   bytes per transfer; last_of_run marks the final result of an item and
//   carries block_done and error_code.
//   One item is worked on at a time; cmd.ready is high only while idle.
//   A bad begin length yields one result. A match is copied from the
//   history RAM, which gives one byte per cycle while the pending result
//   word has room; a full result word holds the reads until it is handed
//   over.
//   Reset clears the control state but rd_ptr and fwd_data, and closes any
//   block; history contents are not cleared and need no clearing pass. When
//   res stalls, the decoder holds the copy and accepts no item until the
//   pending result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lzss_flag_group_block_decoder #(
  parameter int WINDOW_DEPTH     = lzd_pkg::WINDOW_DEPTH_DEF,
  parameter int MAX_BLOCK        = lzd_pkg::MAX_BLOCK_DEF,
  parameter int BYTES_PER_RESULT = lzd_pkg::BYTES_PER_RESULT_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  lzd_in_if.sink    cmd,
  lzd_out_if.source res
);

  localparam int AW         = $clog2(WINDOW_DEPTH);
  localparam int RING_DEPTH = 1 << AW;
  localparam int CW         = $clog2(BYTES_PER_RESULT + 1);
  localparam int IW         = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;
  localparam int LEN_W      = lzd_pkg::LEN_W;
  localparam int DIST_W     = lzd_pkg::DIST_W;
  localparam int OUT_W      = lzd_pkg::OUT_W;
  localparam int BCNT_W     = lzd_pkg::BCNT_W;
  localparam int MLEN_W     = lzd_pkg::MLEN_W;
  localparam int SLOT_W     = lzd_pkg::SLOT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COPY = 2'd1;
  localparam logic [1:0] S_END  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                    state;
  logic [1:0]                    status;
  logic [1:0]                    phase;
  logic [SLOT_W-1:0]             slot;
  logic [7:0]                    flags;
  logic [LEN_W-1:0]              count;
  logic [LEN_W-1:0]              target;
  logic [DIST_W-1:0]             pdist;
  logic                          last_q;
  logic                          tok;
  logic [lzd_pkg::ERR_W-1:0]     err;
  logic                          done;
  logic [MLEN_W-1:0]             copy_left;
  logic [AW-1:0]                 rd_ptr;
  logic                          inflight;
  logic                          fwd_hit;
  logic [7:0]                    fwd_data;
  logic [BYTES_PER_RESULT-1:0][7:0] pk_data;
  logic [CW-1:0]                 pk_cnt;

  logic                          accept;
  logic                          byte_act;
  logic                          lit;
  logic                          push;
  logic [7:0]                    push_byte;
  logic [7:0]                    ram_q;
  logic                          issue;
  logic                          flush;
  logic                          emit;
  logic                          need;
  logic                          out_free;
  logic                          bad_len;
  logic                          bad_dist;
  logic                          overrun;
  logic [MLEN_W-1:0]             m_len;
  logic [SLOT_W-1:0]             end_slot;
  logic [1:0]                    end_phase;
  logic [lzd_pkg::ERR_W-1:0]     end_err;
  logic                          end_done;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign byte_act  = accept && (cmd.opcode == lzd_pkg::OP_BYTE) && (status == lzd_pkg::ST_ACTIVE);
  assign lit       = byte_act && (phase == lzd_pkg::PH_TOKEN) && !flags[slot[2:0]];
  assign push      = lit || ((state == S_COPY) && inflight);
  assign push_byte = lit ? cmd.byte_value : (fwd_hit ? fwd_data : ram_q);
  assign out_free  = !res.valid || res.ready;

  assign issue = (state == S_COPY) && (copy_left != '0) &&
                 (((CW+1)'(pk_cnt) + (CW+1)'(inflight)) < (CW+1)'(BYTES_PER_RESULT));
  assign flush = (state == S_COPY) && (copy_left != '0) && !inflight &&
                 (pk_cnt == CW'(BYTES_PER_RESULT)) && out_free;
  assign need  = (pk_cnt != '0) || done || (err != lzd_pkg::E_OK);
  assign emit  = (state == S_OUT) && need && out_free;

  assign bad_len  = (cmd.block_length == '0) || (cmd.block_length > LEN_W'(MAX_BLOCK));
  assign m_len    = MLEN_W'(cmd.byte_value) + MLEN_W'(lzd_pkg::MIN_MATCH);
  assign bad_dist = (pdist == '0) || (LEN_W'(pdist) > LEN_W'(WINDOW_DEPTH)) ||
                    (LEN_W'(pdist) > count);
  assign overrun  = LEN_W'(m_len) > (target - count);

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (count[AW-1:0]),
    .wr_data (push_byte),
    .rd_en   (issue),
    .rd_addr (rd_ptr),
    .rd_data (ram_q)
  );

  always_comb begin
    end_slot  = slot;
    end_phase = phase;
    end_err   = err;
    end_done  = 1'b0;
    if ((err == lzd_pkg::E_OK) && tok) begin
      end_slot  = slot + SLOT_W'(1);
      end_phase = lzd_pkg::PH_TOKEN;
      if (count >= target) begin
        if ((flags >> end_slot) != '0) begin
          end_err = lzd_pkg::E_UNUSED;
        end else if (!last_q) begin
          end_err = lzd_pkg::E_TRAIL;
        end else begin
          end_done = 1'b1;
        end
      end else if (end_slot >= SLOT_W'(lzd_pkg::FLAG_BITS)) begin
        end_phase = lzd_pkg::PH_FLAG;
      end
    end
    if ((end_err == lzd_pkg::E_OK) && !end_done && last_q) begin
      end_err = lzd_pkg::E_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status    <= lzd_pkg::ST_IDLE;
      phase     <= lzd_pkg::PH_FLAG;
      slot      <= '0;
      flags     <= '0;
      count     <= '0;
      target    <= '0;
      pdist     <= '0;
      last_q    <= 1'b0;
      tok       <= 1'b0;
      err       <= lzd_pkg::E_OK;
      done      <= 1'b0;
      copy_left <= '0;
      inflight  <= 1'b0;
      fwd_hit   <= 1'b0;
      pk_cnt    <= '0;
      pk_data   <= '0;
    end else begin
      if (push) begin
        count                   <= count + LEN_W'(1);
        pk_data[pk_cnt[IW-1:0]] <= push_byte;
        pk_cnt                  <= pk_cnt + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (cmd.opcode == lzd_pkg::OP_BEGIN)) begin
            count <= '0;
            flags <= '0;
            slot  <= '0;
            phase <= lzd_pkg::PH_FLAG;
            pdist <= '0;
            done  <= 1'b0;
            if (bad_len) begin
              target <= '0;
              status <= lzd_pkg::ST_DROPPED;
              err    <= lzd_pkg::E_OVERRUN;
              state  <= S_OUT;
            end else begin
              target <= cmd.block_length;
              status <= lzd_pkg::ST_ACTIVE;
            end
          end else if (byte_act) begin
            last_q <= cmd.last_byte;
            err    <= lzd_pkg::E_OK;
            done   <= 1'b0;
            tok    <= 1'b0;
            state  <= S_END;
            unique case (phase)
              lzd_pkg::PH_FLAG: begin
                flags <= cmd.byte_value;
                slot  <= '0;
                phase <= lzd_pkg::PH_TOKEN;
              end
              lzd_pkg::PH_TOKEN: begin
                if (lit) begin
                  tok <= 1'b1;
                end else begin
                  pdist <= DIST_W'(cmd.byte_value);
                  phase <= lzd_pkg::PH_DIST_HI;
                end
              end
              lzd_pkg::PH_DIST_HI: begin
                pdist <= {cmd.byte_value, pdist[7:0]};
                phase <= lzd_pkg::PH_LEN;
              end
              lzd_pkg::PH_LEN: begin
                if (bad_dist) begin
                  err <= lzd_pkg::E_BAD_DIST;
                end else if (overrun) begin
                  err <= lzd_pkg::E_OVERRUN;
                end else begin
                  tok       <= 1'b1;
                  copy_left <= m_len;
                  rd_ptr    <= count[AW-1:0] - pdist[AW-1:0];
                  inflight  <= 1'b0;
                  state     <= S_COPY;
                end
              end
              default: ;
            endcase
          end
        end
        S_COPY: begin
          inflight <= issue;
          fwd_hit  <= issue && push && (rd_ptr == count[AW-1:0]);
          fwd_data <= push_byte;
          if (issue) begin
            rd_ptr    <= rd_ptr + AW'(1);
            copy_left <= copy_left - MLEN_W'(1);
          end
          if (flush) begin
            pk_cnt  <= '0;
            pk_data <= '0;
          end
          if ((copy_left == '0) && !inflight) begin
            state <= S_END;
          end
        end
        S_END: begin
          slot  <= end_slot;
          phase <= end_phase;
          err   <= end_err;
          done  <= end_done;
          if (end_err != lzd_pkg::E_OK) begin
            status <= lzd_pkg::ST_DROPPED;
          end else if (end_done) begin
            status <= lzd_pkg::ST_IDLE;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!need || out_free) begin
            pk_cnt  <= '0;
            pk_data <= '0;
            err     <= lzd_pkg::E_OK;
            done    <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (flush || emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flush || emit) begin
      res.out_bytes   <= OUT_W'(pk_data);
      res.byte_count  <= BCNT_W'(pk_cnt);
      res.last_of_run <= emit;
      res.block_done  <= emit && done;
      res.error_code  <= emit ? err : lzd_pkg::E_OK;
    end
  end

  `LZD_ASSERT_ALWAYS(a_pk_bound, clk, rst, pk_cnt <= CW'(BYTES_PER_RESULT), "pack overflow")
  `LZD_ASSERT_IMPL(a_idle_empty, clk, rst, cmd.ready, pk_cnt == '0, "pack not empty at idle")
  `LZD_ASSERT_IMPL(a_copy_exit, clk, rst, (state == S_COPY) && (copy_left == '0) && !inflight,
                   ##1 state == S_END, "copy exit lost")
  `LZD_ASSERT_IMPL(a_done_ok, clk, rst, res.valid && res.block_done,
                   res.last_of_run && (res.error_code == lzd_pkg::E_OK), "done with error")

endmodule

`default_nettype wire

[hw/rtl/lzd_ram.sv]
// ----------------------------------------------------------------------------
// lzd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[tb/sv/lzss_flag_group_block_decoder_test.sv]
// ----------------------------------------------------------------------------
// lzss_flag_group_block_decoder_test
// Drives begin and compressed-byte items into the LZSS block decoder with
// random gaps and output stalls. Every accepted item is decoded by an
// in-bench predictor, and each result word is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzss_flag_group_block_decoder_test;

  localparam int WIN      = lzd_pkg::WINDOW_DEPTH_DEF;
  localparam int MAXB     = lzd_pkg::MAX_BLOCK_DEF;
  localparam int BPR      = lzd_pkg::BYTES_PER_RESULT_DEF;
  localparam int LEN_W    = lzd_pkg::LEN_W;
  localparam int OUT_W    = lzd_pkg::OUT_W;
  localparam int BCNT_W   = lzd_pkg::BCNT_W;
  localparam int ERR_W    = lzd_pkg::ERR_W;
  localparam int SLOT_W   = lzd_pkg::SLOT_W;
  localparam int DIST_W   = lzd_pkg::DIST_W;
  localparam int LIMIT    = 4000000;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic             opcode;
    logic [7:0]       byte_value;
    logic [LEN_W-1:0] block_length;
    logic             last_byte;
  } cmd_item_t;

  typedef struct packed {
    logic [OUT_W-1:0]  out_bytes;
    logic [BCNT_W-1:0] byte_count;
    logic              last_of_run;
    logic              block_done;
    logic [ERR_W-1:0]  error_code;
  } res_word_t;

  logic clk;
  logic rst;
  lzd_in_if  cmd ();
  lzd_out_if res ();

  lzss_flag_group_block_decoder i_dut (.clk(clk), .rst(rst), .cmd(cmd), .res(res));

  cmd_item_t pending_items[$];
  res_word_t expected_words[$];
  int        fail_count;
  int        cycle_count;
  int        word_count;
  int        block_count;
  int        hold_cycles;
  bit        hold_done;
  int        send_gap;
  int        recv_gap;

  // predictor state
  logic [7:0]        hist[0:65535];
  logic [LEN_W-1:0]  dec_count;
  logic [LEN_W-1:0]  tgt_len;
  logic [7:0]        flags;
  logic [SLOT_W-1:0] slot;
  logic [1:0]        phase;
  logic [DIST_W-1:0] pdist;
  logic [1:0]        status;
  res_word_t         run_words[$];
  int                run_fill;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_item(input cmd_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic emit_byte(input logic [7:0] b);
    res_word_t w;
    hist[dec_count[15:0]] = b;
    dec_count = dec_count + LEN_W'(1);
    if (run_fill == 0) begin
      w = '0;
      run_words.insert(run_words.size(), w);
    end
    w = run_words[$];
    w.out_bytes[8*run_fill +: 8] = b;
    w.byte_count = w.byte_count + BCNT_W'(1);
    run_words[$] = w;
    run_fill = (run_fill + 1 >= BPR) ? 0 : run_fill + 1;
  endtask

  task automatic close_run(input bit done, input logic [ERR_W-1:0] err);
    res_word_t w;
    if (run_words.size() == 0) begin
      if (!done && err == lzd_pkg::E_OK) return;
      w = '0;
      run_words.insert(run_words.size(), w);
    end
    w = run_words[$];
    w.last_of_run = 1'b1;
    w.block_done = done;
    w.error_code = err;
    run_words[$] = w;
    foreach (run_words[i]) expected_words.insert(expected_words.size(), run_words[i]);
  endtask

  task automatic decode_item(input cmd_item_t it);
    logic [ERR_W-1:0] err;
    bit done, tok;
    int distance, mlen;
    run_words.delete();
    run_fill = 0;
    err = lzd_pkg::E_OK;
    done = 0;
    tok = 0;
    if (it.opcode == lzd_pkg::OP_BEGIN) begin
      dec_count = '0; flags = '0; slot = '0; phase = lzd_pkg::PH_FLAG; pdist = '0;
      if (it.block_length == 0 || it.block_length > MAXB) begin
        tgt_len = '0;
        status = lzd_pkg::ST_DROPPED;
        close_run(0, lzd_pkg::E_OVERRUN);
      end else begin
        tgt_len = it.block_length;
        status = lzd_pkg::ST_ACTIVE;
      end
      return;
    end
    if (status != lzd_pkg::ST_ACTIVE) return;
    case (phase)
      lzd_pkg::PH_FLAG: begin
        flags = it.byte_value; slot = '0; phase = lzd_pkg::PH_TOKEN;
      end
      lzd_pkg::PH_TOKEN: begin
        if (!flags[slot[2:0]]) begin
          emit_byte(it.byte_value);
          tok = 1;
        end else begin
          pdist = {8'h00, it.byte_value};
          phase = lzd_pkg::PH_DIST_HI;
        end
      end
      lzd_pkg::PH_DIST_HI: begin
        pdist[15:8] = it.byte_value;
        phase = lzd_pkg::PH_LEN;
      end
      default: begin
        distance = pdist;
        mlen = it.byte_value + lzd_pkg::MIN_MATCH;
        if (distance == 0 || distance > WIN || distance > dec_count) begin
          err = lzd_pkg::E_BAD_DIST;
        end else if (mlen > tgt_len - dec_count) begin
          err = lzd_pkg::E_OVERRUN;
        end else begin
          for (int i = 0; i < mlen; i++) emit_byte(hist[16'(dec_count - distance)]);
          tok = 1;
        end
      end
    endcase
    if (err == lzd_pkg::E_OK && tok) begin
      slot = slot + SLOT_W'(1);
      phase = lzd_pkg::PH_TOKEN;
      if (dec_count >= tgt_len) begin
        if ((flags >> slot) != 0) err = lzd_pkg::E_UNUSED;
        else if (!it.last_byte) err = lzd_pkg::E_TRAIL;
        else done = 1;
      end else if (slot >= lzd_pkg::FLAG_BITS) begin
        phase = lzd_pkg::PH_FLAG;
      end
    end
    if (err == lzd_pkg::E_OK && !done && it.last_byte) err = lzd_pkg::E_TRUNC;
    if (err != lzd_pkg::E_OK) status = lzd_pkg::ST_DROPPED;
    else if (done) status = lzd_pkg::ST_IDLE;
    close_run(done, err);
  endtask

  function automatic cmd_item_t mk_begin(input int len);
    cmd_item_t it;
    it.opcode = lzd_pkg::OP_BEGIN;
    it.byte_value = 8'($urandom);
    it.block_length = LEN_W'(len);
    it.last_byte = 1'($urandom);
    return it;
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit last);
    cmd_item_t it;
    it.opcode = lzd_pkg::OP_BYTE;
    it.byte_value = b;
    it.block_length = LEN_W'($urandom);
    it.last_byte = last;
    queue_item(it);
  endtask

  // Well-formed block, optionally corrupted, with random content.
  task automatic push_block(input int len, input int fault);
    int made, grp, f, mlen, distance, cut, nbytes;
    bit stop;
    cmd_item_t it;
    queue_item(mk_begin(len));
    block_count++;
    made = 0;
    nbytes = 0;
    cut = (fault == 1) ? $urandom_range(1, 6) : -1;
    stop = 0;
    while (made < len && !stop) begin
      f = 0;
      grp = 0;
      for (int s = 0; s < 8 && made + grp < len; s++) begin
        if (made + grp > 0 && $urandom_range(0, 2) == 0 && len - (made + grp) >= 3) begin
          f |= 1 << s;
          grp += 3;
        end else grp += 1;
      end
      if (fault == 4) f |= 8'h80;
      push_byte(8'(f), 0);
      for (int s = 0; s < 8 && made < len && !stop; s++) begin
        if (f[s] && len - made >= 3 && made > 0) begin
          mlen = $urandom_range(3, (len - made > 20) ? 20 : len - made);
          distance = $urandom_range(1, made);
          if (fault == 2) distance = ($urandom_range(0, 1)) ? 0 : made + 1;
          if (fault == 3) mlen = 258;
          push_byte(8'(distance), 0);
          push_byte(8'(distance >> 8), 0);
          push_byte(8'(mlen - lzd_pkg::MIN_MATCH), 0);
          made += mlen;
          if (fault == 2 || fault == 3) stop = 1;
        end else if (f[s]) begin
          stop = 1;
        end else begin
          push_byte(8'($urandom), 0);
          made++;
        end
        nbytes++;
        if (nbytes == cut) stop = 1;
      end
    end
    if (fault != 5) begin
      it = pending_items[$];
      it.last_byte = 1'b1;
      pending_items[$] = it;
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      cmd.opcode <= lzd_pkg::OP_BEGIN;
      cmd.byte_value <= '0;
      cmd.block_length <= '0;
      cmd.last_byte <= 1'b0;
      send_gap <= 0;
    end else if (!cmd.valid || cmd.ready) begin
      if (cmd.valid) decode_item(pending_items.pop_front());
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        cmd.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cmd.valid <= 1'b1;
        {cmd.opcode, cmd.byte_value, cmd.block_length, cmd.last_byte} <= pending_items[0];
        send_gap <= gap_len();
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // long receiver hold, started once results are flowing
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && word_count >= 20) begin
      hold_cycles <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    res_word_t w, e;
    if (rst) begin
      res.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (res.valid && res.ready) begin
        w = {res.out_bytes, res.byte_count, res.last_of_run, res.block_done, res.error_code};
        word_count++;
        if (expected_words.size() == 0) begin
          $error("unexpected result word %h", w);
          fail_count++;
        end else begin
          e = expected_words.pop_front();
          if (w.out_bytes !== e.out_bytes) begin
            $error("out_bytes exp %h got %h", e.out_bytes, w.out_bytes); fail_count++;
          end
          if (w.byte_count !== e.byte_count) begin
            $error("byte_count exp %0d got %0d", e.byte_count, w.byte_count); fail_count++;
          end
          if (w.last_of_run !== e.last_of_run) begin
            $error("last_of_run exp %0d got %0d", e.last_of_run, w.last_of_run); fail_count++;
          end
          if (w.block_done !== e.block_done) begin
            $error("block_done exp %0d got %0d", e.block_done, w.block_done); fail_count++;
          end
          if (w.error_code !== e.error_code) begin
            $error("error_code exp %0d got %0d", e.error_code, w.error_code); fail_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        res.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        recv_gap <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int fault;
    dec_count = '0; tgt_len = '0; flags = '0; slot = '0;
    phase = lzd_pkg::PH_FLAG; pdist = '0; status = lzd_pkg::ST_IDLE;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: bad lengths, stray bytes, extremes, trailing and truncated blocks
    queue_item(mk_begin(0));
    queue_item(mk_begin(MAXB + 1));
    queue_item(mk_begin(131071));
    push_byte(8'hFF, 1);
    queue_item(mk_begin(1));
    push_byte(8'h00, 0); push_byte(8'hFF, 1);
    queue_item(mk_begin(4));
    push_byte(8'h02, 0); push_byte(8'hA5, 0);
    push_byte(8'h01, 0); push_byte(8'h00, 0); push_byte(8'h00, 1);
    queue_item(mk_begin(2));
    push_byte(8'h00, 0); push_byte(8'h11, 0); push_byte(8'h22, 0);
    queue_item(mk_begin(MAXB));
    push_byte(8'h02, 0); push_byte(8'h5A, 0);
    push_byte(8'h01, 0); push_byte(8'h00, 0); push_byte(8'hFF, 0);
    push_byte(8'h00, 1);
    // longest match, completing the block
    queue_item(mk_begin(259));
    push_byte(8'h02, 0); push_byte(8'hAB, 0);
    push_byte(8'h01, 0); push_byte(8'h00, 0); push_byte(8'hFF, 1);
    for (int k = 0; k < 6; k++) push_block($urandom_range(8, 30), k);

    push_block(200, 0);

    while (pending_items.size() < 370) begin
      fault = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 5);
      if ($urandom_range(0, 19) == 0) push_byte(8'($urandom), 1'($urandom));
      push_block($urandom_range(1, 60), fault);
    end
    push_block(258 + 40, 0);

    wait (pending_items.size() == 0 && !cmd.valid);
    wait (expected_words.size() == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d blocks incl. bad lengths, every error kind and a 258-byte copy",
             block_count);
    $display("checked %0d result words, with one %0d-cycle receiver hold", word_count,
             HOLD_LEN);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
